@@ hdl/ps2_scancode_set2_key_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// ps2 key decoder assertion macros
// shared assertion forms for the checker of the scan code decoder
// ----------------------------------------------------------------------------
`ifndef PS2_SCANCODE_SET2_KEY_DECODER_MACROS_SVH
`define PS2_SCANCODE_SET2_KEY_DECODER_MACROS_SVH

// checked outside reset only
`define PS2KD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PS2KD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/ps2kd_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2kd_pkg
// scan code constants, key kinds and key lookup tables for set 2
// ----------------------------------------------------------------------------
`default_nettype none

package ps2kd_pkg;

  localparam logic [7:0] SC_EXT    = 8'hE0;
  localparam logic [7:0] SC_BREAK  = 8'hF0;
  localparam logic [7:0] SC_LSHIFT = 8'h12;
  localparam logic [7:0] SC_RSHIFT = 8'h59;
  localparam logic [7:0] SC_CTRL   = 8'h14;
  localparam logic [7:0] SC_ALT    = 8'h11;
  localparam logic [7:0] SC_LWIN   = 8'h1f;
  localparam logic [7:0] SC_RWIN   = 8'h27;
  localparam logic [7:0] SC_CAPS   = 8'h58;
  localparam logic [7:0] SC_NUM    = 8'h77;
  localparam logic [7:0] SC_SCROLL = 8'h7e;

  localparam logic [6:0] CASE_DIFF = 7'h20;
  localparam logic [6:0] CTRL_OFS  = 7'h60;

  // modifier bit positions
  localparam logic [2:0] MOD_LSHIFT = 3'd0;
  localparam logic [2:0] MOD_RSHIFT = 3'd1;
  localparam logic [2:0] MOD_LCTRL  = 3'd2;
  localparam logic [2:0] MOD_RCTRL  = 3'd3;
  localparam logic [2:0] MOD_LALT   = 3'd4;
  localparam logic [2:0] MOD_RALT   = 3'd5;
  localparam logic [2:0] MOD_LWIN   = 3'd6;
  localparam logic [2:0] MOD_RWIN   = 3'd7;

  // lock bit masks
  localparam logic [2:0] LOCK_SCROLL = 3'b001;
  localparam logic [2:0] LOCK_NUM    = 3'b010;
  localparam logic [2:0] LOCK_CAPS   = 3'b100;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_FIX,
    KIND_SHF,
    KIND_LET,
    KIND_NUM
  } key_kind_e;

  typedef struct packed {
    logic       hit;
    logic [1:0] zone;
    logic [2:0] row;
    logic [3:0] col;
    key_kind_e  kind;
    logic [6:0] base;
    logic [6:0] alt;
  } key_ent_t;

  function automatic key_ent_t mk(input logic [1:0] zone, input logic [2:0] row,
                                  input logic [3:0] col, input key_kind_e kind,
                                  input logic [6:0] base, input logic [6:0] alt);
    key_ent_t k;
    k.hit  = 1'b1;
    k.zone = zone;
    k.row  = row;
    k.col  = col;
    k.kind = kind;
    k.base = base;
    k.alt  = alt;
    return k;
  endfunction

  function automatic key_ent_t plain_lookup(input logic [7:0] code);
    key_ent_t k;
    k = '0;
    case (code)
      8'h0e: k = mk(2'd0, 3'd0, 4'd0,  KIND_SHF, 7'h60, 7'h7e);
      8'h16: k = mk(2'd0, 3'd0, 4'd1,  KIND_SHF, 7'h31, 7'h21);
      8'h1e: k = mk(2'd0, 3'd0, 4'd2,  KIND_SHF, 7'h32, 7'h40);
      8'h26: k = mk(2'd0, 3'd0, 4'd3,  KIND_SHF, 7'h33, 7'h23);
      8'h25: k = mk(2'd0, 3'd0, 4'd4,  KIND_SHF, 7'h34, 7'h24);
      8'h2e: k = mk(2'd0, 3'd0, 4'd5,  KIND_SHF, 7'h35, 7'h25);
      8'h36: k = mk(2'd0, 3'd0, 4'd6,  KIND_SHF, 7'h36, 7'h5e);
      8'h3d: k = mk(2'd0, 3'd0, 4'd7,  KIND_SHF, 7'h37, 7'h26);
      8'h3e: k = mk(2'd0, 3'd0, 4'd8,  KIND_SHF, 7'h38, 7'h2a);
      8'h46: k = mk(2'd0, 3'd0, 4'd9,  KIND_SHF, 7'h39, 7'h28);
      8'h45: k = mk(2'd0, 3'd0, 4'd10, KIND_SHF, 7'h30, 7'h29);
      8'h4e: k = mk(2'd0, 3'd0, 4'd11, KIND_SHF, 7'h2d, 7'h5f);
      8'h55: k = mk(2'd0, 3'd0, 4'd12, KIND_SHF, 7'h3d, 7'h2b);
      8'h66: k = mk(2'd0, 3'd0, 4'd13, KIND_FIX, 7'h08, 7'h00);
      8'h0d: k = mk(2'd0, 3'd1, 4'd0,  KIND_FIX, 7'h09, 7'h00);
      8'h15: k = mk(2'd0, 3'd1, 4'd1,  KIND_LET, 7'h71, 7'h00);
      8'h1d: k = mk(2'd0, 3'd1, 4'd2,  KIND_LET, 7'h77, 7'h00);
      8'h24: k = mk(2'd0, 3'd1, 4'd3,  KIND_LET, 7'h65, 7'h00);
      8'h2d: k = mk(2'd0, 3'd1, 4'd4,  KIND_LET, 7'h72, 7'h00);
      8'h2c: k = mk(2'd0, 3'd1, 4'd5,  KIND_LET, 7'h74, 7'h00);
      8'h35: k = mk(2'd0, 3'd1, 4'd6,  KIND_LET, 7'h79, 7'h00);
      8'h3c: k = mk(2'd0, 3'd1, 4'd7,  KIND_LET, 7'h75, 7'h00);
      8'h43: k = mk(2'd0, 3'd1, 4'd8,  KIND_LET, 7'h69, 7'h00);
      8'h44: k = mk(2'd0, 3'd1, 4'd9,  KIND_LET, 7'h6f, 7'h00);
      8'h4d: k = mk(2'd0, 3'd1, 4'd10, KIND_LET, 7'h70, 7'h00);
      8'h54: k = mk(2'd0, 3'd1, 4'd11, KIND_SHF, 7'h5b, 7'h7b);
      8'h5b: k = mk(2'd0, 3'd1, 4'd12, KIND_SHF, 7'h5d, 7'h7d);
      8'h5d: k = mk(2'd0, 3'd1, 4'd13, KIND_SHF, 7'h5c, 7'h7c);
      8'h58: k = mk(2'd1, 3'd2, 4'd0,  KIND_NONE, 7'h00, 7'h00);
      8'h1c: k = mk(2'd0, 3'd2, 4'd1,  KIND_LET, 7'h61, 7'h00);
      8'h1b: k = mk(2'd0, 3'd2, 4'd2,  KIND_LET, 7'h73, 7'h00);
      8'h23: k = mk(2'd0, 3'd2, 4'd3,  KIND_LET, 7'h64, 7'h00);
      8'h2b: k = mk(2'd0, 3'd2, 4'd4,  KIND_LET, 7'h66, 7'h00);
      8'h34: k = mk(2'd0, 3'd2, 4'd5,  KIND_LET, 7'h67, 7'h00);
      8'h33: k = mk(2'd0, 3'd2, 4'd6,  KIND_LET, 7'h68, 7'h00);
      8'h3b: k = mk(2'd0, 3'd2, 4'd7,  KIND_LET, 7'h6a, 7'h00);
      8'h42: k = mk(2'd0, 3'd2, 4'd8,  KIND_LET, 7'h6b, 7'h00);
      8'h4b: k = mk(2'd0, 3'd2, 4'd9,  KIND_LET, 7'h6c, 7'h00);
      8'h4c: k = mk(2'd0, 3'd2, 4'd10, KIND_SHF, 7'h3b, 7'h3a);
      8'h52: k = mk(2'd0, 3'd2, 4'd11, KIND_SHF, 7'h27, 7'h22);
      8'h5a: k = mk(2'd0, 3'd2, 4'd12, KIND_FIX, 7'h0d, 7'h00);
      8'h12: k = mk(2'd1, 3'd3, 4'd0,  KIND_NONE, 7'h00, 7'h00);
      8'h1a: k = mk(2'd0, 3'd3, 4'd1,  KIND_LET, 7'h7a, 7'h00);
      8'h22: k = mk(2'd0, 3'd3, 4'd2,  KIND_LET, 7'h78, 7'h00);
      8'h21: k = mk(2'd0, 3'd3, 4'd3,  KIND_LET, 7'h63, 7'h00);
      8'h2a: k = mk(2'd0, 3'd3, 4'd4,  KIND_LET, 7'h76, 7'h00);
      8'h32: k = mk(2'd0, 3'd3, 4'd5,  KIND_LET, 7'h62, 7'h00);
      8'h31: k = mk(2'd0, 3'd3, 4'd6,  KIND_LET, 7'h6e, 7'h00);
      8'h3a: k = mk(2'd0, 3'd3, 4'd7,  KIND_LET, 7'h6d, 7'h00);
      8'h41: k = mk(2'd0, 3'd3, 4'd8,  KIND_SHF, 7'h2c, 7'h3c);
      8'h49: k = mk(2'd0, 3'd3, 4'd9,  KIND_SHF, 7'h2e, 7'h3e);
      8'h4a: k = mk(2'd0, 3'd3, 4'd10, KIND_SHF, 7'h2f, 7'h3f);
      8'h59: k = mk(2'd1, 3'd3, 4'd11, KIND_NONE, 7'h00, 7'h00);
      8'h14: k = mk(2'd1, 3'd4, 4'd0,  KIND_NONE, 7'h00, 7'h00);
      8'h11: k = mk(2'd1, 3'd4, 4'd2,  KIND_NONE, 7'h00, 7'h00);
      8'h29: k = mk(2'd0, 3'd4, 4'd3,  KIND_FIX, 7'h20, 7'h00);
      8'h77: k = mk(2'd2, 3'd0, 4'd0,  KIND_NONE, 7'h00, 7'h00);
      8'h70: k = mk(2'd2, 3'd3, 4'd0,  KIND_NUM, 7'h30, 7'h00);
      8'h69: k = mk(2'd2, 3'd2, 4'd0,  KIND_NUM, 7'h31, 7'h00);
      8'h72: k = mk(2'd2, 3'd2, 4'd1,  KIND_NUM, 7'h32, 7'h00);
      8'h7a: k = mk(2'd2, 3'd2, 4'd2,  KIND_NUM, 7'h33, 7'h00);
      8'h6b: k = mk(2'd2, 3'd1, 4'd0,  KIND_NUM, 7'h34, 7'h00);
      8'h73: k = mk(2'd2, 3'd1, 4'd1,  KIND_NUM, 7'h35, 7'h00);
      8'h74: k = mk(2'd2, 3'd1, 4'd2,  KIND_NUM, 7'h36, 7'h00);
      8'h6c: k = mk(2'd2, 3'd0, 4'd0,  KIND_NUM, 7'h37, 7'h00);
      8'h75: k = mk(2'd2, 3'd0, 4'd1,  KIND_NUM, 7'h38, 7'h00);
      8'h7d: k = mk(2'd2, 3'd0, 4'd2,  KIND_NUM, 7'h39, 7'h00);
      8'h71: k = mk(2'd2, 3'd3, 4'd1,  KIND_NUM, 7'h2e, 7'h00);
      8'h79: k = mk(2'd2, 3'd3, 4'd2,  KIND_FIX, 7'h2b, 7'h00);
      8'h7b: k = mk(2'd2, 3'd0, 4'd3,  KIND_FIX, 7'h2d, 7'h00);
      8'h7c: k = mk(2'd2, 3'd1, 4'd3,  KIND_FIX, 7'h2a, 7'h00);
      8'h7e: k = mk(2'd1, 3'd0, 4'd2,  KIND_NONE, 7'h00, 7'h00);
      8'h76: k = mk(2'd3, 3'd0, 4'd4,  KIND_FIX, 7'h1b, 7'h00);
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic key_ent_t ext_lookup(input logic [7:0] code);
    key_ent_t k;
    k = '0;
    case (code)
      8'h11: k = mk(2'd1, 3'd4, 4'd4, KIND_NONE, 7'h00, 7'h00);
      8'h14: k = mk(2'd1, 3'd4, 4'd7, KIND_NONE, 7'h00, 7'h00);
      8'h1f: k = mk(2'd1, 3'd4, 4'd1, KIND_NONE, 7'h00, 7'h00);
      8'h27: k = mk(2'd1, 3'd4, 4'd5, KIND_NONE, 7'h00, 7'h00);
      8'h2f: k = mk(2'd1, 3'd4, 4'd6, KIND_NONE, 7'h00, 7'h00);
      8'h4a: k = mk(2'd2, 3'd0, 4'd4, KIND_FIX,  7'h2f, 7'h00);
      8'h5a: k = mk(2'd2, 3'd3, 4'd4, KIND_FIX,  7'h0d, 7'h00);
      8'h69: k = mk(2'd3, 3'd1, 4'd1, KIND_NONE, 7'h00, 7'h00);
      8'h6b: k = mk(2'd3, 3'd2, 4'd0, KIND_NONE, 7'h00, 7'h00);
      8'h6c: k = mk(2'd3, 3'd0, 4'd1, KIND_NONE, 7'h00, 7'h00);
      8'h70: k = mk(2'd3, 3'd0, 4'd0, KIND_NONE, 7'h00, 7'h00);
      8'h71: k = mk(2'd3, 3'd1, 4'd0, KIND_FIX,  7'h7f, 7'h00);
      8'h72: k = mk(2'd3, 3'd2, 4'd1, KIND_NONE, 7'h00, 7'h00);
      8'h74: k = mk(2'd3, 3'd2, 4'd2, KIND_NONE, 7'h00, 7'h00);
      8'h75: k = mk(2'd3, 3'd1, 4'd1, KIND_NONE, 7'h00, 7'h00);
      8'h7a: k = mk(2'd3, 3'd1, 4'd2, KIND_NONE, 7'h00, 7'h00);
      8'h7d: k = mk(2'd3, 3'd0, 4'd2, KIND_NONE, 7'h00, 7'h00);
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ps2_scancode_set2_key_decoder.sv @@
// ----------------------------------------------------------------------------
// ps2_scancode_set2_key_decoder
// decodes scan code set 2 bytes into key position, ascii, modifier and lock state
// ----------------------------------------------------------------------------
// usage
//   input channel: one received keyboard byte per item on scan_code_i,
//   taken when in_valid_i is high and in_stall_o is low
//   output channel: one result item per non-prefix byte, held on the
//   output ports while out_valid_o is high and out_stall_i is high
//   prefix bytes e0 and f0 are absorbed and give no result item
//   an accepted byte waits in the input register, is decoded from there and
//   is written to the result register unless the receiver stalls
//   throughput: one item per cycle while the receiver does not stall, set by
//   the single decode stage between the input register and the result register
//   a stalled receiver holds the result register; the input register then
//   fills and in_stall_o rises until the result is taken
//   reset clears the prefixes, all modifiers and all locks, and empties both
//   registers
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_scancode_set2_key_decoder
  import ps2kd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] scan_code_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      code_byte_o,
  output logic            extended_o,
  output logic            released_o,
  output logic            mapped_o,
  output logic [1:0]      key_zone_o,
  output logic [2:0]      key_row_o,
  output logic [3:0]      key_col_o,
  output logic            char_avail_o,
  output logic [6:0]      ascii_code_o,
  output logic [3:0]      held_modifiers_o,
  output logic [2:0]      lock_leds_o,
  output logic            led_update_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_code_q;
  logic       out_valid_q, out_valid_d;

  logic [1:0] pend_q, pend_d;
  logic [7:0] mod_q, mod_d;
  logic [2:0] lock_q, lock_d;

  logic       in_accept, s1_fire, s1_prefix, res_load;
  logic       ext, rel, shift, ctrl;
  logic       mod_hit, lock_hit;
  logic [2:0] mod_idx, lock_mask;
  logic [7:0] mod_nx;
  logic [2:0] lock_nx;
  key_ent_t   key;
  logic       has_nx;
  logic [6:0] ascii_nx;
  logic [3:0] held_nx;

  // handshake
  always_comb begin
    s1_prefix   = (s1_code_q == SC_EXT) || (s1_code_q == SC_BREAK);
    s1_fire     = s1_valid_q && (s1_prefix || !out_valid_q || !out_stall_i);
    in_stall_o  = s1_valid_q && !s1_fire;
    in_accept   = in_valid_i && !in_stall_o;
    res_load    = s1_fire && !s1_prefix;
    s1_valid_d  = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = res_load ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);
  end

  // decode
  always_comb begin
    ext     = pend_q[0];
    rel     = pend_q[1];
    mod_hit = 1'b0;
    mod_idx = MOD_LSHIFT;
    if (ext) begin
      case (s1_code_q)
        SC_CTRL: begin mod_hit = 1'b1; mod_idx = MOD_RCTRL; end
        SC_ALT:  begin mod_hit = 1'b1; mod_idx = MOD_RALT;  end
        SC_LWIN: begin mod_hit = 1'b1; mod_idx = MOD_LWIN;  end
        SC_RWIN: begin mod_hit = 1'b1; mod_idx = MOD_RWIN;  end
        default: mod_hit = 1'b0;
      endcase
    end else begin
      case (s1_code_q)
        SC_LSHIFT: begin mod_hit = 1'b1; mod_idx = MOD_LSHIFT; end
        SC_RSHIFT: begin mod_hit = 1'b1; mod_idx = MOD_RSHIFT; end
        SC_CTRL:   begin mod_hit = 1'b1; mod_idx = MOD_LCTRL;  end
        SC_ALT:    begin mod_hit = 1'b1; mod_idx = MOD_LALT;   end
        default:   mod_hit = 1'b0;
      endcase
    end

    mod_nx = mod_q;
    if (mod_hit) begin
      mod_nx[mod_idx] = !rel;
    end

    lock_mask = 3'b000;
    case (s1_code_q)
      SC_CAPS:   lock_mask = LOCK_CAPS;
      SC_NUM:    lock_mask = LOCK_NUM;
      SC_SCROLL: lock_mask = LOCK_SCROLL;
      default:   lock_mask = 3'b000;
    endcase
    lock_hit = !ext && !rel && (lock_mask != 3'b000);
    lock_nx  = lock_hit ? (lock_q ^ lock_mask) : lock_q;

    key   = ext ? ext_lookup(s1_code_q) : plain_lookup(s1_code_q);
    shift = |mod_nx[1:0];
    ctrl  = |mod_nx[3:2];

    has_nx   = 1'b0;
    ascii_nx = 7'h00;
    case (key.kind)
      KIND_FIX: begin
        has_nx   = 1'b1;
        ascii_nx = key.base;
      end
      KIND_SHF: begin
        has_nx   = 1'b1;
        ascii_nx = shift ? key.alt : key.base;
      end
      KIND_LET: begin
        has_nx = 1'b1;
        if (ctrl) begin
          ascii_nx = key.base - CTRL_OFS;
        end else if (shift != lock_nx[2]) begin
          ascii_nx = key.base - CASE_DIFF;
        end else begin
          ascii_nx = key.base;
        end
      end
      KIND_NUM: begin
        has_nx   = lock_nx[1];
        ascii_nx = lock_nx[1] ? key.base : 7'h00;
      end
      default: begin
        has_nx   = 1'b0;
        ascii_nx = 7'h00;
      end
    endcase

    held_nx = {|mod_nx[7:6], |mod_nx[5:4], ctrl, shift};

    pend_d = pend_q;
    mod_d  = mod_q;
    lock_d = lock_q;
    if (s1_fire) begin
      if (s1_code_q == SC_EXT) begin
        pend_d = pend_q | 2'b01;
      end else if (s1_code_q == SC_BREAK) begin
        pend_d = pend_q | 2'b10;
      end else begin
        pend_d = 2'b00;
        mod_d  = mod_nx;
        lock_d = lock_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 2'b00;
      mod_q       <= 8'h00;
      lock_q      <= 3'b000;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      mod_q       <= mod_d;
      lock_q      <= lock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_code_q <= scan_code_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      code_byte_o      <= s1_code_q;
      extended_o       <= ext;
      released_o       <= rel;
      mapped_o         <= key.hit;
      key_zone_o       <= key.zone;
      key_row_o        <= key.row;
      key_col_o        <= key.col;
      char_avail_o     <= has_nx;
      ascii_code_o     <= ascii_nx;
      held_modifiers_o <= held_nx;
      lock_leds_o      <= lock_nx;
      led_update_o     <= lock_hit;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/ps2kd_checker.sv @@
// ----------------------------------------------------------------------------
// ps2kd_checker
// port level checks for the scan code decoder, bound into the decoder module
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_scancode_set2_key_decoder_macros.svh"

module ps2kd_checker
  import ps2kd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] code_byte_o,
  input wire logic       extended_o,
  input wire logic       released_o,
  input wire logic       char_avail_o,
  input wire logic [6:0] ascii_code_o,
  input wire logic [2:0] lock_leds_o,
  input wire logic       led_update_o
);

  `PS2KD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid in reset")

  `PS2KD_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_byte_o) &&
    $stable(ascii_code_o) && $stable(lock_leds_o),
    "stalled item changed")

  `PS2KD_ASSERT(a_no_prefix_out,
    out_valid_o |-> code_byte_o != SC_EXT && code_byte_o != SC_BREAK,
    "prefix byte gave an item")

  `PS2KD_ASSERT(a_led_on_lock,
    out_valid_o && led_update_o |-> !released_o && !extended_o &&
    (code_byte_o == SC_CAPS || code_byte_o == SC_NUM || code_byte_o == SC_SCROLL),
    "led update without lock press")

  `PS2KD_ASSERT(a_ascii_zero,
    out_valid_o && !char_avail_o |-> ascii_code_o == 7'h00,
    "ascii set without character")

endmodule

bind ps2_scancode_set2_key_decoder ps2kd_checker u_ps2kd_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for ps2_scancode_set2_key_decoder
// drives scan code bytes through the valid/stall input channel and compares
// every result item against a typed table row or a cycle-free model of the
// decoder state (pending prefixes, held modifiers, lock leds); a short table
// of directed bytes comes first, then random key sequences under several
// sender and receiver idle patterns, including one long receiver hold-off
// that backs up the input
`timescale 1ns / 100ps

module testbench;
  import ps2kd_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RAND_PER_PHASE = 106;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [7:0] code;
    logic       ext;
    logic       rel;
    logic       mapped;
    logic [1:0] zone;
    logic [2:0] row;
    logic [3:0] col;
    logic       char_avail;
    logic [6:0] ascii;
    logic [3:0] mods;
    logic [2:0] leds;
    logic       led_upd;
  } key_result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] zone;
    logic [2:0] row;
    logic [3:0] col;
    key_kind_e  kind;
    logic [6:0] base;
    logic [6:0] alt;
  } key_info_t;

  typedef struct packed {
    logic [7:0]  scan;
    logic        typed;
    key_result_t want;
  } stim_row_t;

  localparam int DIR_N = 26;
  localparam stim_row_t DIR_TAB [0:DIR_N-1] = '{
    '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 3'd0, 4'd0, 1'b0, 7'h00, 4'h0, 3'h0, 1'b0}},
    '{8'hff, 1'b1, '{8'hff, 1'b0, 1'b0, 1'b0, 2'd0, 3'd0, 4'd0, 1'b0, 7'h00, 4'h0, 3'h0, 1'b0}},
    '{SC_EXT, 1'b0, '0},
    '{SC_EXT, 1'b0, '0},
    '{8'h12, 1'b1, '{8'h12, 1'b1, 1'b0, 1'b0, 2'd0, 3'd0, 4'd0, 1'b0, 7'h00, 4'h0, 3'h0, 1'b0}},
    '{SC_BREAK, 1'b0, '0},
    '{SC_BREAK, 1'b0, '0},
    '{8'h58, 1'b1, '{8'h58, 1'b0, 1'b1, 1'b1, 2'd1, 3'd2, 4'd0, 1'b0, 7'h00, 4'h0, 3'h0, 1'b0}},
    '{8'h58, 1'b1, '{8'h58, 1'b0, 1'b0, 1'b1, 2'd1, 3'd2, 4'd0, 1'b0, 7'h00, 4'h0, 3'h4, 1'b1}},
    '{8'h1c, 1'b0, '0},
    '{8'h12, 1'b0, '0},
    '{8'h1c, 1'b0, '0},
    '{8'h14, 1'b0, '0},
    '{8'h16, 1'b0, '0},
    '{8'h1c, 1'b0, '0},
    '{8'h77, 1'b0, '0},
    '{8'h70, 1'b0, '0},
    '{SC_EXT, 1'b0, '0},
    '{8'h71, 1'b0, '0},
    '{SC_EXT, 1'b0, '0},
    '{8'h7e, 1'b0, '0},
    '{SC_BREAK, 1'b0, '0},
    '{8'h12, 1'b0, '0},
    '{8'h71, 1'b0, '0},
    '{SC_EXT, 1'b0, '0},
    '{8'h1f, 1'b0, '0}
  };

  // modifier and lock keys, bit 8 marks an extended code
  localparam logic [8:0] HOT_KEYS [0:10] = '{
    9'h012, 9'h059, 9'h014, 9'h011, 9'h058, 9'h077, 9'h07e,
    9'h114, 9'h111, 9'h11f, 9'h127
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] scan_code_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] code_byte_o;
  logic       extended_o;
  logic       released_o;
  logic       mapped_o;
  logic [1:0] key_zone_o;
  logic [2:0] key_row_o;
  logic [3:0] key_col_o;
  logic       char_avail_o;
  logic [6:0] ascii_code_o;
  logic [3:0] held_modifiers_o;
  logic [2:0] lock_leds_o;
  logic       led_update_o;

  ps2_scancode_set2_key_decoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .scan_code_i      (scan_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_byte_o      (code_byte_o),
    .extended_o       (extended_o),
    .released_o       (released_o),
    .mapped_o         (mapped_o),
    .key_zone_o       (key_zone_o),
    .key_row_o        (key_row_o),
    .key_col_o        (key_col_o),
    .char_avail_o     (char_avail_o),
    .ascii_code_o     (ascii_code_o),
    .held_modifiers_o (held_modifiers_o),
    .lock_leds_o      (lock_leds_o),
    .led_update_o     (led_update_o)
  );

  always #4 clk_i = ~clk_i;

  // decoder state mirror
  logic       pend_ext = 1'b0;
  logic       pend_brk = 1'b0;
  logic [7:0] mod_keys = 8'h00;
  logic [2:0] lock_bits = 3'h0;

  key_result_t exp_q[$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          cycle_cnt = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  function automatic key_info_t kent(input logic [1:0] zone, input logic [2:0] row,
                                     input logic [3:0] col, input key_kind_e kind,
                                     input logic [6:0] base, input logic [6:0] alt);
    key_info_t k;
    k = '{1'b1, zone, row, col, kind, base, alt};
    return k;
  endfunction

  function automatic key_info_t key_lookup(input logic ext, input logic [7:0] sc);
    key_info_t k;
    k = '0;
    if (ext) begin
      case (sc)
        8'h11: k = kent(2'd1, 3'd4, 4'd4, KIND_NONE, 7'h00, 7'h00);
        8'h14: k = kent(2'd1, 3'd4, 4'd7, KIND_NONE, 7'h00, 7'h00);
        8'h1f: k = kent(2'd1, 3'd4, 4'd1, KIND_NONE, 7'h00, 7'h00);
        8'h27: k = kent(2'd1, 3'd4, 4'd5, KIND_NONE, 7'h00, 7'h00);
        8'h2f: k = kent(2'd1, 3'd4, 4'd6, KIND_NONE, 7'h00, 7'h00);
        8'h4a: k = kent(2'd2, 3'd0, 4'd4, KIND_FIX, 7'h2f, 7'h00);
        8'h5a: k = kent(2'd2, 3'd3, 4'd4, KIND_FIX, 7'h0d, 7'h00);
        8'h69: k = kent(2'd3, 3'd1, 4'd1, KIND_NONE, 7'h00, 7'h00);
        8'h6b: k = kent(2'd3, 3'd2, 4'd0, KIND_NONE, 7'h00, 7'h00);
        8'h6c: k = kent(2'd3, 3'd0, 4'd1, KIND_NONE, 7'h00, 7'h00);
        8'h70: k = kent(2'd3, 3'd0, 4'd0, KIND_NONE, 7'h00, 7'h00);
        8'h71: k = kent(2'd3, 3'd1, 4'd0, KIND_FIX, 7'h7f, 7'h00);
        8'h72: k = kent(2'd3, 3'd2, 4'd1, KIND_NONE, 7'h00, 7'h00);
        8'h74: k = kent(2'd3, 3'd2, 4'd2, KIND_NONE, 7'h00, 7'h00);
        8'h75: k = kent(2'd3, 3'd1, 4'd1, KIND_NONE, 7'h00, 7'h00);
        8'h7a: k = kent(2'd3, 3'd1, 4'd2, KIND_NONE, 7'h00, 7'h00);
        8'h7d: k = kent(2'd3, 3'd0, 4'd2, KIND_NONE, 7'h00, 7'h00);
        default: k = '0;
      endcase
    end else begin
      case (sc)
        8'h0e: k = kent(2'd0, 3'd0, 4'd0, KIND_SHF, 7'h60, 7'h7e);
        8'h16: k = kent(2'd0, 3'd0, 4'd1, KIND_SHF, 7'h31, 7'h21);
        8'h1e: k = kent(2'd0, 3'd0, 4'd2, KIND_SHF, 7'h32, 7'h40);
        8'h26: k = kent(2'd0, 3'd0, 4'd3, KIND_SHF, 7'h33, 7'h23);
        8'h25: k = kent(2'd0, 3'd0, 4'd4, KIND_SHF, 7'h34, 7'h24);
        8'h2e: k = kent(2'd0, 3'd0, 4'd5, KIND_SHF, 7'h35, 7'h25);
        8'h36: k = kent(2'd0, 3'd0, 4'd6, KIND_SHF, 7'h36, 7'h5e);
        8'h3d: k = kent(2'd0, 3'd0, 4'd7, KIND_SHF, 7'h37, 7'h26);
        8'h3e: k = kent(2'd0, 3'd0, 4'd8, KIND_SHF, 7'h38, 7'h2a);
        8'h46: k = kent(2'd0, 3'd0, 4'd9, KIND_SHF, 7'h39, 7'h28);
        8'h45: k = kent(2'd0, 3'd0, 4'd10, KIND_SHF, 7'h30, 7'h29);
        8'h4e: k = kent(2'd0, 3'd0, 4'd11, KIND_SHF, 7'h2d, 7'h5f);
        8'h55: k = kent(2'd0, 3'd0, 4'd12, KIND_SHF, 7'h3d, 7'h2b);
        8'h66: k = kent(2'd0, 3'd0, 4'd13, KIND_FIX, 7'h08, 7'h00);
        8'h0d: k = kent(2'd0, 3'd1, 4'd0, KIND_FIX, 7'h09, 7'h00);
        8'h15: k = kent(2'd0, 3'd1, 4'd1, KIND_LET, 7'h71, 7'h00);
        8'h1d: k = kent(2'd0, 3'd1, 4'd2, KIND_LET, 7'h77, 7'h00);
        8'h24: k = kent(2'd0, 3'd1, 4'd3, KIND_LET, 7'h65, 7'h00);
        8'h2d: k = kent(2'd0, 3'd1, 4'd4, KIND_LET, 7'h72, 7'h00);
        8'h2c: k = kent(2'd0, 3'd1, 4'd5, KIND_LET, 7'h74, 7'h00);
        8'h35: k = kent(2'd0, 3'd1, 4'd6, KIND_LET, 7'h79, 7'h00);
        8'h3c: k = kent(2'd0, 3'd1, 4'd7, KIND_LET, 7'h75, 7'h00);
        8'h43: k = kent(2'd0, 3'd1, 4'd8, KIND_LET, 7'h69, 7'h00);
        8'h44: k = kent(2'd0, 3'd1, 4'd9, KIND_LET, 7'h6f, 7'h00);
        8'h4d: k = kent(2'd0, 3'd1, 4'd10, KIND_LET, 7'h70, 7'h00);
        8'h54: k = kent(2'd0, 3'd1, 4'd11, KIND_SHF, 7'h5b, 7'h7b);
        8'h5b: k = kent(2'd0, 3'd1, 4'd12, KIND_SHF, 7'h5d, 7'h7d);
        8'h5d: k = kent(2'd0, 3'd1, 4'd13, KIND_SHF, 7'h5c, 7'h7c);
        8'h58: k = kent(2'd1, 3'd2, 4'd0, KIND_NONE, 7'h00, 7'h00);
        8'h1c: k = kent(2'd0, 3'd2, 4'd1, KIND_LET, 7'h61, 7'h00);
        8'h1b: k = kent(2'd0, 3'd2, 4'd2, KIND_LET, 7'h73, 7'h00);
        8'h23: k = kent(2'd0, 3'd2, 4'd3, KIND_LET, 7'h64, 7'h00);
        8'h2b: k = kent(2'd0, 3'd2, 4'd4, KIND_LET, 7'h66, 7'h00);
        8'h34: k = kent(2'd0, 3'd2, 4'd5, KIND_LET, 7'h67, 7'h00);
        8'h33: k = kent(2'd0, 3'd2, 4'd6, KIND_LET, 7'h68, 7'h00);
        8'h3b: k = kent(2'd0, 3'd2, 4'd7, KIND_LET, 7'h6a, 7'h00);
        8'h42: k = kent(2'd0, 3'd2, 4'd8, KIND_LET, 7'h6b, 7'h00);
        8'h4b: k = kent(2'd0, 3'd2, 4'd9, KIND_LET, 7'h6c, 7'h00);
        8'h4c: k = kent(2'd0, 3'd2, 4'd10, KIND_SHF, 7'h3b, 7'h3a);
        8'h52: k = kent(2'd0, 3'd2, 4'd11, KIND_SHF, 7'h27, 7'h22);
        8'h5a: k = kent(2'd0, 3'd2, 4'd12, KIND_FIX, 7'h0d, 7'h00);
        8'h12: k = kent(2'd1, 3'd3, 4'd0, KIND_NONE, 7'h00, 7'h00);
        8'h1a: k = kent(2'd0, 3'd3, 4'd1, KIND_LET, 7'h7a, 7'h00);
        8'h22: k = kent(2'd0, 3'd3, 4'd2, KIND_LET, 7'h78, 7'h00);
        8'h21: k = kent(2'd0, 3'd3, 4'd3, KIND_LET, 7'h63, 7'h00);
        8'h2a: k = kent(2'd0, 3'd3, 4'd4, KIND_LET, 7'h76, 7'h00);
        8'h32: k = kent(2'd0, 3'd3, 4'd5, KIND_LET, 7'h62, 7'h00);
        8'h31: k = kent(2'd0, 3'd3, 4'd6, KIND_LET, 7'h6e, 7'h00);
        8'h3a: k = kent(2'd0, 3'd3, 4'd7, KIND_LET, 7'h6d, 7'h00);
        8'h41: k = kent(2'd0, 3'd3, 4'd8, KIND_SHF, 7'h2c, 7'h3c);
        8'h49: k = kent(2'd0, 3'd3, 4'd9, KIND_SHF, 7'h2e, 7'h3e);
        8'h4a: k = kent(2'd0, 3'd3, 4'd10, KIND_SHF, 7'h2f, 7'h3f);
        8'h59: k = kent(2'd1, 3'd3, 4'd11, KIND_NONE, 7'h00, 7'h00);
        8'h14: k = kent(2'd1, 3'd4, 4'd0, KIND_NONE, 7'h00, 7'h00);
        8'h11: k = kent(2'd1, 3'd4, 4'd2, KIND_NONE, 7'h00, 7'h00);
        8'h29: k = kent(2'd0, 3'd4, 4'd3, KIND_FIX, 7'h20, 7'h00);
        8'h77: k = kent(2'd2, 3'd0, 4'd0, KIND_NONE, 7'h00, 7'h00);
        8'h70: k = kent(2'd2, 3'd3, 4'd0, KIND_NUM, 7'h30, 7'h00);
        8'h69: k = kent(2'd2, 3'd2, 4'd0, KIND_NUM, 7'h31, 7'h00);
        8'h72: k = kent(2'd2, 3'd2, 4'd1, KIND_NUM, 7'h32, 7'h00);
        8'h7a: k = kent(2'd2, 3'd2, 4'd2, KIND_NUM, 7'h33, 7'h00);
        8'h6b: k = kent(2'd2, 3'd1, 4'd0, KIND_NUM, 7'h34, 7'h00);
        8'h73: k = kent(2'd2, 3'd1, 4'd1, KIND_NUM, 7'h35, 7'h00);
        8'h74: k = kent(2'd2, 3'd1, 4'd2, KIND_NUM, 7'h36, 7'h00);
        8'h6c: k = kent(2'd2, 3'd0, 4'd0, KIND_NUM, 7'h37, 7'h00);
        8'h75: k = kent(2'd2, 3'd0, 4'd1, KIND_NUM, 7'h38, 7'h00);
        8'h7d: k = kent(2'd2, 3'd0, 4'd2, KIND_NUM, 7'h39, 7'h00);
        8'h71: k = kent(2'd2, 3'd3, 4'd1, KIND_NUM, 7'h2e, 7'h00);
        8'h79: k = kent(2'd2, 3'd3, 4'd2, KIND_FIX, 7'h2b, 7'h00);
        8'h7b: k = kent(2'd2, 3'd0, 4'd3, KIND_FIX, 7'h2d, 7'h00);
        8'h7c: k = kent(2'd2, 3'd1, 4'd3, KIND_FIX, 7'h2a, 7'h00);
        8'h7e: k = kent(2'd1, 3'd0, 4'd2, KIND_NONE, 7'h00, 7'h00);
        8'h76: k = kent(2'd3, 3'd0, 4'd4, KIND_FIX, 7'h1b, 7'h00);
        default: k = '0;
      endcase
    end
    return k;
  endfunction

  task automatic decode_scan(input logic [7:0] sc, output logic emits, output key_result_t ev);
    key_info_t k;
    logic      shift;
    logic      ctrl;
    logic      upd;
    emits = 1'b0;
    ev    = '0;
    upd   = 1'b0;
    if (sc == SC_EXT) begin
      pend_ext = 1'b1;
    end else if (sc == SC_BREAK) begin
      pend_brk = 1'b1;
    end else begin
      if (pend_ext) begin
        case (sc)
          SC_CTRL: mod_keys[MOD_RCTRL] = ~pend_brk;
          SC_ALT:  mod_keys[MOD_RALT]  = ~pend_brk;
          SC_LWIN: mod_keys[MOD_LWIN]  = ~pend_brk;
          SC_RWIN: mod_keys[MOD_RWIN]  = ~pend_brk;
          default: ;
        endcase
      end else begin
        case (sc)
          SC_LSHIFT: mod_keys[MOD_LSHIFT] = ~pend_brk;
          SC_RSHIFT: mod_keys[MOD_RSHIFT] = ~pend_brk;
          SC_CTRL:   mod_keys[MOD_LCTRL]  = ~pend_brk;
          SC_ALT:    mod_keys[MOD_LALT]   = ~pend_brk;
          SC_CAPS, SC_NUM, SC_SCROLL: begin
            if (!pend_brk) begin
              lock_bits = lock_bits ^ (sc == SC_CAPS ? LOCK_CAPS :
                                       sc == SC_NUM ? LOCK_NUM : LOCK_SCROLL);
              upd = 1'b1;
            end
          end
          default: ;
        endcase
      end
      k     = key_lookup(pend_ext, sc);
      shift = |mod_keys[1:0];
      ctrl  = |mod_keys[3:2];
      ev.code    = sc;
      ev.ext     = pend_ext;
      ev.rel     = pend_brk;
      ev.mapped  = k.hit;
      ev.zone    = k.zone;
      ev.row     = k.row;
      ev.col     = k.col;
      if (k.hit) begin
        case (k.kind)
          KIND_FIX: begin
            ev.char_avail = 1'b1;
            ev.ascii      = k.base;
          end
          KIND_SHF: begin
            ev.char_avail = 1'b1;
            ev.ascii      = shift ? k.alt : k.base;
          end
          KIND_LET: begin
            ev.char_avail = 1'b1;
            ev.ascii      = k.base;
            if (shift != ((lock_bits & LOCK_CAPS) != 3'h0)) ev.ascii = k.base - CASE_DIFF;
            if (ctrl) ev.ascii = k.base - CTRL_OFS;
          end
          KIND_NUM: begin
            ev.char_avail = (lock_bits & LOCK_NUM) != 3'h0;
            ev.ascii      = ev.char_avail ? k.base : 7'h00;
          end
          default: ;
        endcase
      end
      ev.mods    = {|mod_keys[7:6], |mod_keys[5:4], ctrl, shift};
      ev.leds    = lock_bits;
      ev.led_upd = upd;
      emits      = 1'b1;
      pend_ext   = 1'b0;
      pend_brk   = 1'b0;
    end
  endtask

  task automatic send_scan(input logic [7:0] sc, input logic typed, input key_result_t want);
    logic        emits;
    key_result_t ev;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_code_i <= sc;
    do @(posedge clk_i); while (in_stall_o);
    decode_scan(sc, emits, ev);
    if (emits) exp_q.push_back(typed ? want : ev);
    sent_cnt++;
  endtask

  task automatic send_key(input logic ext, input logic rel, input logic [7:0] sc);
    if (ext) send_scan(SC_EXT, 1'b0, '0);
    if (rel) send_scan(SC_BREAK, 1'b0, '0);
    send_scan(sc, 1'b0, '0);
  endtask

  task automatic send_random_sequence();
    int         pick;
    logic       ext;
    logic [7:0] sc;
    logic [8:0] hot;
    key_info_t  ki;
    pick = $urandom_range(99);
    if (pick < 60) begin
      ext = ($urandom_range(3) == 0);
      do begin
        sc = 8'($urandom_range(127));
        ki = key_lookup(ext, sc);
      end while (!ki.hit);
      send_key(ext, $urandom_range(99) < 40, sc);
    end else if (pick < 82) begin
      hot = HOT_KEYS[4'($urandom_range(10))];
      send_key(hot[8], $urandom_range(1) == 1, hot[7:0]);
    end else begin
      // noise and broken prefix runs
      if ($urandom_range(1) == 1) send_scan($urandom_range(1) ? SC_EXT : SC_BREAK, 1'b0, '0);
      send_scan(8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  // receiver: random stall plus long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    key_result_t got;
    key_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{code_byte_o, extended_o, released_o, mapped_o, key_zone_o, key_row_o,
              key_col_o, char_avail_o, ascii_code_o, held_modifiers_o, lock_leds_o,
              led_update_o};
      if (exp_q.size() == 0) begin
        $error("unexpected item: code_byte %0h", got.code);
        err_cnt++;
      end else begin
        want = exp_q.pop_front();
        if (got.code != want.code) begin
          $error("code_byte: expected %0h, got %0h", want.code, got.code);
          err_cnt++;
        end
        if (got.ext != want.ext) begin
          $error("extended: expected %0h, got %0h", want.ext, got.ext);
          err_cnt++;
        end
        if (got.rel != want.rel) begin
          $error("released: expected %0h, got %0h", want.rel, got.rel);
          err_cnt++;
        end
        if (got.mapped != want.mapped) begin
          $error("mapped: expected %0h, got %0h", want.mapped, got.mapped);
          err_cnt++;
        end
        if (got.zone != want.zone) begin
          $error("key_zone: expected %0h, got %0h", want.zone, got.zone);
          err_cnt++;
        end
        if (got.row != want.row) begin
          $error("key_row: expected %0h, got %0h", want.row, got.row);
          err_cnt++;
        end
        if (got.col != want.col) begin
          $error("key_col: expected %0h, got %0h", want.col, got.col);
          err_cnt++;
        end
        if (got.char_avail != want.char_avail) begin
          $error("char_avail: expected %0h, got %0h", want.char_avail, got.char_avail);
          err_cnt++;
        end
        if (got.ascii != want.ascii) begin
          $error("ascii_code: expected %0h, got %0h", want.ascii, got.ascii);
          err_cnt++;
        end
        if (got.mods != want.mods) begin
          $error("held_modifiers: expected %0h, got %0h", want.mods, got.mods);
          err_cnt++;
        end
        if (got.leds != want.leds) begin
          $error("lock_leds: expected %0h, got %0h", want.leds, got.leds);
          err_cnt++;
        end
        if (got.led_upd != want.led_upd) begin
          $error("led_update: expected %0h, got %0h", want.led_upd, got.led_upd);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int start_cnt;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_scan(DIR_TAB[i].scan, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 59; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      if (ph == 0) begin
        // back up the pipeline behind a long receiver hold-off
        hold_req++;
        start_cnt = sent_cnt;
        while (sent_cnt < start_cnt + 30) send_random_sequence();
      end
      while (sent_cnt < DIR_N + (ph + 1) * RAND_PER_PHASE) send_random_sequence();
    end
    in_valid_i <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
